FILE: rtl/edd_pkg.sv
// Package for the error diffusion dither: payload structs, register codes,
// error saturation and the sixteenths share function.
// No dependencies; used by edd_lane, the top level and the testbench.
package edd_pkg;

  // Field widths fixed by the stream format.
  localparam int SAMPLE_W   = 8;
  localparam int ERR_W      = 11;
  localparam int IMG_W_W    = 11;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;
  // Number of sample fields a pixel carries.
  localparam int SLOTS      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 4'd1;

  // Register reset values.
  localparam logic [IMG_W_W-1:0] WIDTH_RESET     = 11'd512;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd127;

  // Stored error range.
  localparam logic signed [13:0] ERR_MIN = -14'sd1024;
  localparam logic signed [13:0] ERR_MAX = 14'sd1023;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_c0;
    logic [SAMPLE_W-1:0] sample_c1;
    logic [SAMPLE_W-1:0] sample_c2;
    logic                frame_start;
  } pix_in_t;

  typedef struct packed {
    logic bit_c0;
    logic bit_c1;
    logic bit_c2;
    logic row_end;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_t;

  // Control that the pixel stage hands to every lane.
  typedef struct packed {
    logic adv;    // pixel in the work stage moves on this cycle
    logic clear;  // pixel opens a frame: row carries start from zero
    logic last;   // pixel ends its row
  } lane_ctl_t;

  // Clamp a wide signed sum into the stored error range.
  function automatic err_t sat_err(input logic signed [13:0] x);
    err_t r;
    if (x < ERR_MIN) begin
      r = err_t'(ERR_MIN);
    end else if (x > ERR_MAX) begin
      r = err_t'(ERR_MAX);
    end else begin
      r = err_t'(x);
    end
    return r;
  endfunction

  // (e * k) / 16 with truncation toward zero.
  function automatic logic signed [12:0] share16(input logic signed [12:0] e,
                                                 input logic signed [4:0] k);
    logic signed [16:0] p;
    logic signed [16:0] q;
    p = 17'(e) * 17'(k);
    q = (p < 17'sd0) ? (p + 17'sd15) : p;
    return 13'(q >>> 4);
  endfunction

endpackage

FILE: rtl/edd_chan_if.sv
// Valid/ready channel carrying one payload struct per transfer.
// Depends on nothing; the payload type comes in as a parameter.
interface edd_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/edd_lane.sv
// One dither lane: quantizes a corrected sample and spreads its error.
// Holds the right carry and the two partial sums for the row below.
// Depends on edd_pkg.
module edd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  edd_pkg::lane_ctl_t            ctl,
  input  logic [edd_pkg::SAMPLE_W-1:0]  sample,
  input  edd_pkg::err_t                 above,
  input  logic [edd_pkg::THR_W-1:0]     threshold,
  output logic                          px_bit,
  output edd_pkg::err_t                 left_err,
  output edd_pkg::err_t                 here_err
);

  edd_pkg::err_t carry, below_left, below_here;
  edd_pkg::err_t carry_next, below_left_next, below_here_next;
  edd_pkg::err_t carry_in, bl_in, bh_in;
  logic signed [12:0] v, thr_s, e;
  logic signed [12:0] s1, s3, s5, s7;

  // A frame start discards whatever the previous frame left in the carries.
  always_comb begin
    carry_in = ctl.clear ? '0 : carry;
    bl_in    = ctl.clear ? '0 : below_left;
    bh_in    = ctl.clear ? '0 : below_here;
  end

  // Corrected value, quantization and the four error shares.
  always_comb begin
    v      = 13'(signed'({1'b0, sample})) + 13'(carry_in) + 13'(above);
    thr_s  = 13'(signed'({1'b0, threshold}));
    px_bit = (v > thr_s);
    e      = px_bit ? (v - 13'sd255) : v;
    s1     = edd_pkg::share16(e, 5'sd1);
    s3     = edd_pkg::share16(e, 5'sd3);
    s5     = edd_pkg::share16(e, 5'sd5);
    s7     = edd_pkg::share16(e, 5'sd7);
  end

  // Finished entries for the row below: left neighbor and this column.
  always_comb begin
    left_err = edd_pkg::sat_err(14'(bl_in) + 14'(s3));
    here_err = edd_pkg::sat_err(14'(bh_in) + 14'(s5));
  end

  // Carries move one column right, or start over at the end of a row.
  always_comb begin
    if (ctl.last) begin
      carry_next      = '0;
      below_left_next = '0;
      below_here_next = '0;
    end else begin
      carry_next      = edd_pkg::sat_err(14'(s7));
      below_left_next = here_err;
      below_here_next = edd_pkg::sat_err(14'(s1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry      <= '0;
      below_left <= '0;
      below_here <= '0;
    end else if (ctl.adv) begin
      carry      <= carry_next;
      below_left <= below_left_next;
      below_here <= below_here_next;
    end
  end

endmodule

FILE: rtl/edd_line_buf.sv
// Line buffer of diffused errors for the next row, all lanes in one word.
// One write and one registered read per cycle, with forwarding of the write
// that lands on the read edge and of the held end-of-row entry; no package.
module edd_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          tail_set,
  input  logic [AW-1:0] tail_col,
  input  logic [DW-1:0] tail_data,
  output logic [DW-1:0] rd_word
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr_q;
  logic          byp_hit;
  logic [DW-1:0] byp_data;
  logic          tail_valid;
  logic [AW-1:0] tail_addr;
  logic [DW-1:0] tail_word;
  logic          flush_pend;

  // Storage write port. A held row end is copied to storage in the cycle after
  // it is held, which has no down-left write since its pixel sits in column 0.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end else if (flush_pend) begin
      mem[tail_addr] <= tail_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_pend <= 1'b0;
    end else begin
      flush_pend <= tail_set;
    end
  end

  // Registered read; a write at the same edge is caught for forwarding.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      byp_hit   <= wr_en && (wr_addr == rd_addr);
      byp_data  <= wr_data;
    end
  end

  // The last column of a row is held in a register until overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
    end else if (tail_set) begin
      tail_valid <= 1'b1;
    end else if (wr_en && (wr_addr == tail_addr)) begin
      tail_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_set) begin
      tail_addr <= tail_col;
      tail_word <= tail_data;
    end
  end

  // Newest copy wins: held row end, then same-edge write, then storage.
  always_comb begin
    if (tail_valid && (tail_addr == rd_addr_q)) begin
      rd_word = tail_word;
    end else if (byp_hit) begin
      rd_word = byp_data;
    end else begin
      rd_word = rd_data;
    end
  end

endmodule

FILE: rtl/error_diffusion_dither.sv
// Floyd-Steinberg error diffusion, one pixel per cycle while the result side
// keeps up, lanes side by side. A pixel waits in the work stage for its line
// buffer read and its bits then load the result register; the rate rests on
// the one-read, one-write line buffer and the lane carry loop.
// Reset: width 512, threshold 127, column 0, first row; line buffer content
// is undefined after reset, and the first row of each frame does not use it.
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024,
  parameter int LANES     = 3
) (
  input  logic       clk,
  input  logic       rst,
  edd_chan_if.sink   pixels,
  edd_chan_if.source results,
  edd_chan_if.sink   cfg
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > edd_pkg::IMG_W_W) ? AW + 1 : edd_pkg::IMG_W_W;
  localparam int NL = (LANES > edd_pkg::SLOTS) ? edd_pkg::SLOTS : LANES;
  localparam int DW = NL * edd_pkg::ERR_W;

  logic [edd_pkg::IMG_W_W-1:0] image_width;
  logic [edd_pkg::THR_W-1:0]   threshold;

  logic [AW-1:0] col_cnt;
  logic          first_row;

  logic              s1_valid;
  edd_pkg::pix_in_t  s1_pix;
  logic [AW-1:0]     s1_col;
  logic              s1_last;
  logic              s1_first;

  logic              out_valid;
  edd_pkg::pix_out_t out_data;

  logic          in_xfer, s1_adv, cfg_xfer;
  logic          fs;
  logic [AW-1:0] col_base, col_cur, col_m1;
  logic          first_eff, last_cur;
  logic [WW-1:0] w_ext, w_eff, w_m1;

  logic [DW-1:0] rd_word, wr_word, tail_word;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [2:0]    lane_bits;
  logic [edd_pkg::SAMPLE_W-1:0] lane_sample [edd_pkg::SLOTS];
  edd_pkg::lane_ctl_t lane_ctl;

  // Handshakes: the work stage drains into the output register.
  assign in_xfer       = pixels.valid && pixels.ready;
  assign s1_adv        = s1_valid && (!out_valid || results.ready);
  assign pixels.ready  = !s1_valid || s1_adv;
  assign cfg.ready     = 1'b1;
  assign cfg_xfer      = cfg.valid && cfg.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= edd_pkg::WIDTH_RESET;
      threshold   <= edd_pkg::THRESHOLD_RESET;
    end else if (cfg_xfer) begin
      case (cfg.data.index)
        edd_pkg::REG_IMAGE_WIDTH: image_width <= cfg.data.value;
        edd_pkg::REG_THRESHOLD:   threshold   <= cfg.data.value[edd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Column of the incoming pixel, clamped to the effective row width.
  always_comb begin
    fs        = pixels.data.frame_start;
    col_base  = fs ? '0 : col_cnt;
    first_eff = fs ? 1'b1 : first_row;
    w_ext     = WW'(image_width);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_m1     = w_eff - WW'(1);
    col_cur  = (col_base > w_m1[AW-1:0]) ? w_m1[AW-1:0] : col_base;
    last_cur = (col_cur == w_m1[AW-1:0]);
  end

  // Raster position advances at each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      first_row <= 1'b1;
    end else if (in_xfer) begin
      col_cnt   <= last_cur ? '0 : (col_cur + AW'(1));
      first_row <= last_cur ? 1'b0 : first_eff;
    end
  end

  // Work stage holds the pixel while the line buffer read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix   <= pixels.data;
      s1_col   <= col_cur;
      s1_last  <= last_cur;
      s1_first <= first_eff;
    end
  end

  // Down-left entry goes to storage; the row end entry is held aside.
  assign col_m1  = s1_col - AW'(1);
  assign wr_en   = s1_adv && (s1_col != '0);
  assign wr_addr = col_m1;

  edd_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (DW)
  ) u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_xfer),
    .rd_addr   (col_cur),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_word),
    .tail_set  (s1_adv && s1_last),
    .tail_col  (s1_col),
    .tail_data (tail_word),
    .rd_word   (rd_word)
  );

  assign lane_sample[0] = s1_pix.sample_c0;
  assign lane_sample[1] = s1_pix.sample_c1;
  assign lane_sample[2] = s1_pix.sample_c2;

  always_comb begin
    lane_ctl.adv   = s1_adv;
    lane_ctl.clear = s1_pix.frame_start;
    lane_ctl.last  = s1_last;
  end

  // Parallel lanes; channels without a lane report zero.
  for (genvar k = 0; k < edd_pkg::SLOTS; k++) begin : g_lane
    if (k < NL) begin : g_on
      edd_pkg::err_t above;
      edd_pkg::err_t left_err, here_err;

      assign above = s1_first ? '0 : rd_word[k*edd_pkg::ERR_W +: edd_pkg::ERR_W];

      edd_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .ctl       (lane_ctl),
        .sample    (lane_sample[k]),
        .above     (above),
        .threshold (threshold),
        .px_bit    (lane_bits[k]),
        .left_err  (left_err),
        .here_err  (here_err)
      );

      assign wr_word[k*edd_pkg::ERR_W +: edd_pkg::ERR_W]   = left_err;
      assign tail_word[k*edd_pkg::ERR_W +: edd_pkg::ERR_W] = here_err;
    end else begin : g_off
      assign lane_bits[k] = 1'b0;
    end
  end

  // Merge the lane bits into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.bit_c0  <= lane_bits[0];
      out_data.bit_c1  <= lane_bits[1];
      out_data.bit_c2  <= lane_bits[2];
      out_data.row_end <= s1_last;
    end
  end

endmodule

FILE: tb/tb_error_diffusion_dither.sv
// Self-checking testbench for error_diffusion_dither: a directed table, then random raster
// phases, predicted by an error diffusion model in this file unless a row pins its bits.
// Depends on edd_pkg, edd_chan_if and error_diffusion_dither.
module tb_error_diffusion_dither;

  localparam int LINE_DEPTH    = 1024;
  localparam int NUM_LANES     = 3;
  localparam int RAND_ITEMS    = 1430;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 300000;
  // Index that matches no register; a write to it must change nothing.
  localparam logic [edd_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd15;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_EVERY4, STALL_SPARSE} stall_mode_t;

  // One line of the directed stimulus table.
  typedef struct packed {
    row_kind_t          kind;
    edd_pkg::pix_in_t   pix;
    logic               pinned;
    edd_pkg::pix_out_t  bits;
    edd_pkg::cfg_t      reg_wr;
  } dir_row_t;

  logic clk;
  logic rst;

  edd_chan_if #(.T(edd_pkg::pix_in_t))  pix_if ();
  edd_chan_if #(.T(edd_pkg::pix_out_t)) res_if ();
  edd_chan_if #(.T(edd_pkg::cfg_t))     cfg_if ();

  error_diffusion_dither #(
    .MAX_WIDTH(LINE_DEPTH),
    .LANES    (NUM_LANES)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_if),
    .results(res_if),
    .cfg    (cfg_if)
  );

  // Shadow registers and diffusion state of the predictor.
  logic [edd_pkg::IMG_W_W-1:0] width_reg;
  logic [edd_pkg::THR_W-1:0]   thresh_reg;
  edd_pkg::err_t      line_err [LINE_DEPTH][NUM_LANES];
  edd_pkg::err_t      carry_err [NUM_LANES];
  edd_pkg::err_t      left_below [NUM_LANES];
  edd_pkg::err_t      here_below [NUM_LANES];
  int unsigned        col_next;
  logic               in_first_row;

  edd_pkg::pix_out_t dithered_q [$];
  edd_pkg::pix_out_t predicted_bits;
  edd_pkg::pix_out_t oldest_bits;
  int       fail_count = 0;
  int       burst_left = 0;
  int       cycle_count;

  // Fixed expectation that travels with a directed pixel.
  logic              pin_flag;
  edd_pkg::pix_out_t pin_bits;

  logic        sink_ready = 1'b0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  logic [2:0]  stall_phase = '0;

  assign res_if.ready = sink_ready;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_width(input logic [edd_pkg::IMG_W_W-1:0] w);
    if (w == '0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic edd_pkg::err_t clamp_err(input int x);
    if (x < -1024) return -11'sd1024;
    if (x > 1023) return 11'sd1023;
    return edd_pkg::err_t'(x);
  endfunction

  // Integer division in SystemVerilog truncates toward zero, as required.
  function automatic int sixteenths(input int e, input int k);
    return (e * k) / 16;
  endfunction

  // Quantize one pixel on all lanes and diffuse its error; updates the state.
  function automatic edd_pkg::pix_out_t dither_pixel(input edd_pkg::pix_in_t px);
    logic [7:0]  samp [NUM_LANES];
    logic [2:0]  lane_bits;
    int unsigned w;
    int unsigned c;
    logic        at_end;
    int          v;
    int          e;
    int          above;
    edd_pkg::err_t     below_sum;
    edd_pkg::pix_out_t r;
    samp[0] = px.sample_c0;
    samp[1] = px.sample_c1;
    samp[2] = px.sample_c2;
    if (px.frame_start) begin
      col_next = 0;
      in_first_row = 1'b1;
      for (int k = 0; k < NUM_LANES; k++) begin
        carry_err[k] = '0;
        left_below[k] = '0;
        here_below[k] = '0;
      end
    end
    w = eff_width(width_reg);
    c = (col_next >= w) ? w - 1 : col_next;
    at_end = (c == w - 1);
    for (int k = 0; k < NUM_LANES; k++) begin
      above = in_first_row ? 0 : int'(line_err[c][k]);
      v = int'(samp[k]) + int'(carry_err[k]) + above;
      lane_bits[k] = (v > int'(thresh_reg));
      e = lane_bits[k] ? v - 255 : v;
      if (c > 0) begin
        line_err[c-1][k] = clamp_err(int'(left_below[k]) + sixteenths(e, 3));
      end
      below_sum = clamp_err(int'(here_below[k]) + sixteenths(e, 5));
      if (at_end) begin
        line_err[c][k] = below_sum;
        carry_err[k] = '0;
        left_below[k] = '0;
        here_below[k] = '0;
      end else begin
        left_below[k] = below_sum;
        here_below[k] = clamp_err(sixteenths(e, 1));
        carry_err[k] = clamp_err(sixteenths(e, 7));
      end
    end
    if (at_end) begin
      col_next = 0;
      in_first_row = 1'b0;
    end else begin
      col_next = c + 1;
    end
    r.bit_c0 = lane_bits[0];
    r.bit_c1 = lane_bits[1];
    r.bit_c2 = lane_bits[2];
    r.row_end = at_end;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Track register writes, predict accepted pixels and check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.data.index)
          edd_pkg::REG_IMAGE_WIDTH: width_reg = cfg_if.data.value;
          edd_pkg::REG_THRESHOLD:   thresh_reg = cfg_if.data.value[edd_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (pix_if.valid && pix_if.ready) begin
        predicted_bits = dither_pixel(pix_if.data);
        dithered_q.push_back(pin_flag ? pin_bits : predicted_bits);
      end
      if (res_if.valid && res_if.ready) begin
        if (dithered_q.size() == 0) begin
          $display("%0t: result with no pixel pending, expected none, actual %b",
                   $time, res_if.data);
          fail_count++;
        end else begin
          oldest_bits = dithered_q.pop_front();
          check_field("bit_c0", oldest_bits.bit_c0, res_if.data.bit_c0);
          check_field("bit_c1", oldest_bits.bit_c1, res_if.data.bit_c1);
          check_field("bit_c2", oldest_bits.bit_c2, res_if.data.bit_c2);
          check_field("row_end", oldest_bits.row_end, res_if.data.row_end);
        end
      end
    end
  end

  // Result stalls: a random pattern, replaced by another when its hold count runs out.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   sink_ready <= 1'b1;
        STALL_COIN:   sink_ready <= 1'($urandom_range(0, 1));
        STALL_EVERY4: sink_ready <= (stall_phase[1:0] != 2'd3);
        default:      sink_ready <= (stall_phase == 3'd0);
      endcase
      stall_phase <= stall_phase + 3'd1;
    end
  end

  // Send one pixel in bursts with random gaps; returns at the transfer edge.
  task automatic feed_pixel(input edd_pkg::pix_in_t px, input logic pin,
                            input edd_pkg::pix_out_t bits);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    burst_left--;
    pix_if.valid <= 1'b1;
    pix_if.data <= px;
    pin_flag <= pin;
    pin_bits <= bits;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic drain_pipe();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (dithered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; valid stays high so back-to-back writes need no gap.
  task automatic write_reg(input logic [edd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [edd_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  function automatic dir_row_t pix_row(input logic [7:0] s0, s1, s2, input logic fs);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.pix = '{sample_c0: s0, sample_c1: s1, sample_c2: s2, frame_start: fs};
    return r;
  endfunction

  function automatic dir_row_t pinned_row(input logic [7:0] s0, s1, s2, input logic fs,
                                          input edd_pkg::pix_out_t bits);
    dir_row_t r;
    r = pix_row(s0, s1, s2, fs);
    r.pinned = 1'b1;
    r.bits = bits;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [edd_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [edd_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_wr = '{index: idx, value: val};
    return r;
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Directed table: reset defaults, threshold and width extremes, frame starts.
  task automatic run_directed();
    dir_row_t rows [$];
    // Reset state: width 512, threshold 127, first row without a frame start.
    rows.push_back(pinned_row(8'd0, 8'd0, 8'd0, 1'b0, 4'b0000));
    rows.push_back(pinned_row(8'd255, 8'd255, 8'd255, 1'b0, 4'b1110));
    rows.push_back(pinned_row(8'd127, 8'd128, 8'd127, 1'b0, 4'b0100));
    rows.push_back(pix_row(8'd255, 8'd0, 8'd128, 1'b0));
    // Width lowered mid-row: the next pixel closes the row.
    rows.push_back(cfg_row(edd_pkg::REG_IMAGE_WIDTH, 11'd3));
    rows.push_back(pix_row(8'd10, 8'd200, 8'd90, 1'b0));
    rows.push_back(pix_row(8'd60, 8'd0, 8'd255, 1'b0));
    rows.push_back(pix_row(8'd255, 8'd140, 8'd1, 1'b0));
    rows.push_back(pix_row(8'd0, 8'd255, 8'd127, 1'b0));
    // Threshold at zero: any positive value gives full scale.
    rows.push_back(cfg_row(edd_pkg::REG_THRESHOLD, 11'd0));
    rows.push_back(pinned_row(8'd0, 8'd0, 8'd0, 1'b1, 4'b0000));
    rows.push_back(pinned_row(8'd1, 8'd1, 8'd1, 1'b0, 4'b1110));
    rows.push_back(pinned_row(8'd0, 8'd0, 8'd0, 1'b0, 4'b0001));
    // Threshold at full scale: only positive carried or diffused error can lift a pixel above it.
    rows.push_back(cfg_row(edd_pkg::REG_THRESHOLD, 11'd255));
    rows.push_back(pinned_row(8'd255, 8'd255, 8'd255, 1'b1, 4'b0000));
    rows.push_back(pinned_row(8'd255, 8'd255, 8'd255, 1'b0, 4'b1110));
    // Width zero acts as a one-pixel row.
    rows.push_back(cfg_row(edd_pkg::REG_IMAGE_WIDTH, 11'd0));
    rows.push_back(pinned_row(8'd200, 8'd50, 8'd255, 1'b1, 4'b0001));
    rows.push_back(pix_row(8'd255, 8'd255, 8'd255, 1'b0));
    // Oversized width saturates to the line buffer depth.
    rows.push_back(cfg_row(edd_pkg::REG_IMAGE_WIDTH, 11'd2047));
    rows.push_back(pix_row(8'd128, 8'd127, 8'd0, 1'b1));
    rows.push_back(cfg_row(edd_pkg::REG_THRESHOLD, 11'd127));
    rows.push_back(pix_row(8'd255, 8'd0, 8'd255, 1'b0));
    rows.push_back(cfg_row(REG_SPARE, 11'd5));
    rows.push_back(cfg_row(edd_pkg::REG_IMAGE_WIDTH, 11'd1024));
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(rows[i].reg_wr.index, rows[i].reg_wr.value);
        cfg_if.valid <= 1'b0;
      end else begin
        feed_pixel(rows[i].pix, rows[i].pinned, rows[i].bits);
      end
    end
  endtask

  // Random phases: new settings while idle, then raster rows with random content.
  task automatic run_random();
    int          items_left;
    int          n;
    int          pick;
    int unsigned old_span;
    int unsigned new_span;
    logic [edd_pkg::IMG_W_W-1:0] new_w;
    logic [edd_pkg::THR_W-1:0]   new_thr;
    logic        keep_frame;
    logic        wide_done;
    edd_pkg::pix_in_t px;
    items_left = RAND_ITEMS;
    wide_done = 1'b0;
    while (items_left > 0) begin
      drain_pipe();
      old_span = eff_width(width_reg);
      pick = $urandom_range(0, 19);
      if (!wide_done && items_left < RAND_ITEMS - 300) begin
        // One frame of 96 to 160 columns whose errors carry past its first row.
        new_w = edd_pkg::IMG_W_W'($urandom_range(96, 160));
        wide_done = 1'b1;
        n = new_w + $urandom_range(8, new_w);
      end else begin
        if (pick == 0) begin
          new_w = '0;
        end else if (pick == 1) begin
          new_w = edd_pkg::IMG_W_W'($urandom_range(1025, 2047));
        end else if (pick == 2) begin
          new_w = edd_pkg::IMG_W_W'($urandom_range(65, 1024));
        end else if (pick <= 12) begin
          new_w = edd_pkg::IMG_W_W'($urandom_range(1, 8));
        end else if (pick <= 17) begin
          new_w = edd_pkg::IMG_W_W'($urandom_range(9, 24));
        end else begin
          new_w = edd_pkg::IMG_W_W'($urandom_range(25, 64));
        end
        new_span = eff_width(new_w);
        // Wide rows stay partial; narrow ones run several full rows.
        if (new_span > 64) begin
          n = $urandom_range(4, 24);
        end else begin
          n = new_span * $urandom_range(2, 5) + $urandom_range(0, new_span);
        end
      end
      new_span = eff_width(new_w);
      case ($urandom_range(0, 9))
        0:       new_thr = 8'd0;
        1:       new_thr = 8'd255;
        default: new_thr = 8'($urandom_range(0, 255));
      endcase
      write_reg(edd_pkg::REG_IMAGE_WIDTH, new_w);
      write_reg(edd_pkg::REG_THRESHOLD, edd_pkg::CFG_DATA_W'(new_thr));
      cfg_if.valid <= 1'b0;
      // A grown row, or a first row cut short, would read buffer entries never
      // written, so either case opens a frame.
      keep_frame = !in_first_row && (new_span <= old_span) && ($urandom_range(0, 1) == 1);
      if (n > items_left) n = items_left;
      for (int i = 0; i < n; i++) begin
        px.sample_c0 = rand_sample();
        px.sample_c1 = rand_sample();
        px.sample_c2 = rand_sample();
        px.frame_start = (i == 0 && !keep_frame) || ($urandom_range(0, 59) == 0);
        feed_pixel(px, 1'b0, '0);
      end
      items_left -= n;
    end
  endtask

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    pin_flag = 1'b0;
    pin_bits = '0;
    width_reg = edd_pkg::WIDTH_RESET;
    thresh_reg = edd_pkg::THRESHOLD_RESET;
    col_next = 0;
    in_first_row = 1'b1;
    for (int k = 0; k < NUM_LANES; k++) begin
      carry_err[k] = '0;
      left_below[k] = '0;
      here_below[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    drain_pipe();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
